### sv/hpik_pkg.sv
// shared types, register indexes and helpers for the hanging plotter inverse kinematics
package hpik_pkg;

	// configuration register indexes
	localparam logic [3:0] REG_MOTOR_SPACING  = 4'd0;
	localparam logic [3:0] REG_FRAME_HEIGHT   = 4'd1;
	localparam logic [3:0] REG_MOTOR_Y_OFFSET = 4'd2;
	localparam logic [3:0] REG_X_SCALE        = 4'd3;
	localparam logic [3:0] REG_Y_SCALE        = 4'd4;
	localparam logic [3:0] REG_A_STEPS_PER_MM = 4'd5;
	localparam logic [3:0] REG_B_STEPS_PER_MM = 4'd6;
	localparam logic [3:0] REG_Z_STEPS_PER_MM = 4'd7;

	// unity scale and one step per mm at reset, and the step count saturation limits
	localparam logic [17:0] SCALE_ONE   = 18'd65536;
	localparam logic [31:0] STEPS_ONE   = 32'd65536;
	localparam logic [31:0] STEPS_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] STEPS_MIN   = 32'h8000_0000;

	// width of the chain length root and of the radicand
	localparam int ROOT_W = 51;
	localparam int RAD_W  = 2 * ROOT_W;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} target_t;

	typedef struct packed {
		logic signed [31:0] left_chain_steps;
		logic signed [31:0] right_chain_steps;
		logic signed [31:0] z_steps;
		logic               overflow;
	} result_t;

	// magnitude of a distance that is known to stay below 2^50
	function automatic logic [49:0] mag50(input logic signed [51:0] v);
		logic [51:0] n;
		n = v[51] ? 52'(-v) : 52'(v);
		return n[49:0];
	endfunction

endpackage

### sv/hpik_isqrt.sv
// two-lane pipelined integer square root, one root bit per stage
module hpik_isqrt #(
	parameter int RW     = 51,
	parameter int SIDE_W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [2*RW-1:0]     rad_a,
	input  logic [2*RW-1:0]     rad_b,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_valid,
	output logic [RW-1:0]       root_a,
	output logic [RW-1:0]       root_b,
	output logic [SIDE_W-1:0]   side_out
);
	localparam int SW = 2 * RW;

	logic [SW-1:0]     rem_q   [RW][2];
	logic [RW-1:0]     root_q  [RW][2];
	logic [SIDE_W-1:0] side_q  [RW];
	logic              valid_q [RW];

	for (genvar g = 0; g < RW; g++) begin : g_stage
		localparam int B = RW - 1 - g;
		logic [SW-1:0] rem_in  [2];
		logic [RW-1:0] root_in [2];
		logic [SW-1:0] rem_nx  [2];
		logic [RW-1:0] root_nx [2];

		// stage input: radicand or previous stage
		if (g == 0) begin : g_first
			assign rem_in[0]  = rad_a;
			assign rem_in[1]  = rad_b;
			assign root_in[0] = '0;
			assign root_in[1] = '0;
		end else begin : g_next
			assign rem_in[0]  = rem_q[g-1][0];
			assign rem_in[1]  = rem_q[g-1][1];
			assign root_in[0] = root_q[g-1][0];
			assign root_in[1] = root_q[g-1][1];
		end

		// try root bit B: subtract 2^(B+1)*root + 2^(2B)
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [SW-1:0] trial;
			logic          fits;
			always_comb begin
				trial = ({{RW{1'b0}}, root_in[l]} << (B + 1)) | (SW'(1) << (2 * B));
				fits  = rem_in[l] >= trial;
				rem_nx[l]  = fits ? rem_in[l] - trial : rem_in[l];
				root_nx[l] = root_in[l] | (RW'(fits) << B);
			end
		end

		always_ff @(posedge clk) begin
			rem_q[g][0]  <= rem_nx[0];
			rem_q[g][1]  <= rem_nx[1];
			root_q[g][0] <= root_nx[0];
			root_q[g][1] <= root_nx[1];
			side_q[g]    <= (g == 0) ? side_in : side_q[(g == 0) ? 0 : g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[g] <= 1'b0;
			end else begin
				valid_q[g] <= (g == 0) ? in_valid : valid_q[(g == 0) ? 0 : g-1];
			end
		end
	end

	assign out_valid = valid_q[RW-1];
	assign root_a    = root_q[RW-1][0];
	assign root_b    = root_q[RW-1][1];
	assign side_out  = side_q[RW-1];

endmodule

### sv/hanging_plotter_inverse_kinematics.sv
// top level: two-chain hanging plotter inverse kinematics pipeline
//
//  channel   ports                                   beat taken when
//  target    start, busy, target                     start & !busy
//  result    done, result                            done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// one target enters every cycle; busy never rises
// the pipeline has five setup stages, 51 square root stages (one root bit
// each), one multiply stage and one round and saturate stage
// reset clears all valid bits and loads the register reset values
// the result side cannot stall, so nothing in the pipeline ever holds
module hanging_plotter_inverse_kinematics #(
	parameter int POS_FRAC_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hpik_pkg::target_t target,
	output logic              done,
	output hpik_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import hpik_pkg::*;

	localparam int K  = POS_FRAC_BITS + 32;
	localparam int ZK = POS_FRAC_BITS + 16;

	// configuration registers
	logic [22:0]        spacing_q;
	logic [22:0]        height_q;
	logic signed [23:0] y_off_q;
	logic [17:0]        x_scale_q;
	logic [17:0]        y_scale_q;
	logic [31:0]        a_spm_q;
	logic [31:0]        b_spm_q;
	logic [31:0]        z_spm_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= '0;
			height_q  <= '0;
			y_off_q   <= '0;
			x_scale_q <= SCALE_ONE;
			y_scale_q <= SCALE_ONE;
			a_spm_q   <= STEPS_ONE;
			b_spm_q   <= STEPS_ONE;
			z_spm_q   <= STEPS_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MOTOR_SPACING:  spacing_q <= cfg_data[22:0];
				REG_FRAME_HEIGHT:   height_q  <= cfg_data[22:0];
				REG_MOTOR_Y_OFFSET: y_off_q   <= cfg_data[23:0];
				REG_X_SCALE:        x_scale_q <= cfg_data[17:0];
				REG_Y_SCALE:        y_scale_q <= cfg_data[17:0];
				REG_A_STEPS_PER_MM: a_spm_q   <= cfg_data;
				REG_B_STEPS_PER_MM: b_spm_q   <= cfg_data;
				REG_Z_STEPS_PER_MM: z_spm_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits of the setup and output stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_c1, v_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_c1 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_c1 <= v_sq;
			done <= v_c1;
		end
	end

	// stage 1: scale correction
	logic signed [50:0] xs_s1, ys_s1;
	logic signed [31:0] pz_s1;

	always_ff @(posedge clk) begin
		xs_s1 <= target.pos_x * $signed({1'b0, x_scale_q});
		ys_s1 <= target.pos_y * $signed({1'b0, y_scale_q});
		pz_s1 <= target.pos_z;
	end

	// stage 2: distances to the motors
	logic signed [51:0] xc_e, yc_e;
	logic [49:0]        d_s2 [3];
	logic signed [31:0] pz_s2;

	always_comb begin
		xc_e = $signed({14'b0, spacing_q, 15'b0});
		yc_e = $signed({14'b0, height_q, 15'b0}) + $signed({{12{y_off_q[23]}}, y_off_q, 16'b0});
	end

	always_ff @(posedge clk) begin
		d_s2[0] <= mag50(xc_e + {xs_s1[50], xs_s1});
		d_s2[1] <= mag50(xc_e - {xs_s1[50], xs_s1});
		d_s2[2] <= mag50(yc_e - {ys_s1[50], ys_s1});
		pz_s2   <= pz_s1;
	end

	// stage 3: partial products of the squares
	logic [49:0]        hh_s3 [3];
	logic [49:0]        hl_s3 [3];
	logic [49:0]        ll_s3 [3];
	logic signed [31:0] pz_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hh_s3[i] <= d_s2[i][49:25] * d_s2[i][49:25];
			hl_s3[i] <= d_s2[i][49:25] * d_s2[i][24:0];
			ll_s3[i] <= d_s2[i][24:0] * d_s2[i][24:0];
		end
		pz_s3 <= pz_s2;
	end

	// stage 4: assemble the squares
	logic [99:0]        sq_s4 [3];
	logic signed [31:0] pz_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= {hh_s3[i], 50'b0} + {24'b0, hl_s3[i], 26'b0} + {50'b0, ll_s3[i]};
		end
		pz_s4 <= pz_s3;
	end

	// stage 5: radicands of both chains
	logic [RAD_W-1:0]   rad_l_s5, rad_r_s5;
	logic signed [31:0] pz_s5;

	always_ff @(posedge clk) begin
		rad_l_s5 <= RAD_W'({1'b0, sq_s4[0]} + {1'b0, sq_s4[2]});
		rad_r_s5 <= RAD_W'({1'b0, sq_s4[1]} + {1'b0, sq_s4[2]});
		pz_s5    <= pz_s4;
	end

	// chain lengths
	logic [ROOT_W-1:0] len_l, len_r;
	logic [31:0]       pz_sq;

	hpik_isqrt #(
		.RW     (ROOT_W),
		.SIDE_W (32)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.rad_a     (rad_l_s5),
		.rad_b     (rad_r_s5),
		.side_in   (pz_s5),
		.out_valid (v_sq),
		.root_a    (len_l),
		.root_b    (len_r),
		.side_out  (pz_sq)
	);

	// output stage 1: steps per mm products
	logic [57:0] l_lo_c1, r_lo_c1;
	logic [56:0] l_hi_c1, r_hi_c1;
	logic [63:0] zm_c1;
	logic        zneg_c1;
	logic [31:0] zabs;

	assign zabs = pz_sq[31] ? (~pz_sq + 32'd1) : pz_sq;

	always_ff @(posedge clk) begin
		l_lo_c1 <= len_l[25:0] * a_spm_q;
		l_hi_c1 <= len_l[50:26] * a_spm_q;
		r_lo_c1 <= len_r[25:0] * b_spm_q;
		r_hi_c1 <= len_r[50:26] * b_spm_q;
		zm_c1   <= zabs * z_spm_q;
		zneg_c1 <= pz_sq[31];
	end

	// output stage 2: round half away from zero and saturate
	logic [83:0] psum_l, psum_r, q_l, q_r;
	logic [64:0] zr, zneg_v;
	logic        sat_l, sat_r, sat_z;
	logic [31:0] z_v;
	result_t     res_nx;

	always_comb begin
		psum_l = {1'b0, l_hi_c1, 26'b0} + {26'b0, l_lo_c1} + (84'(1) << (K - 1));
		psum_r = {1'b0, r_hi_c1, 26'b0} + {26'b0, r_lo_c1} + (84'(1) << (K - 1));
		q_l    = psum_l >> K;
		q_r    = psum_r >> K;
		sat_l  = |q_l[83:31];
		sat_r  = |q_r[83:31];
		zr     = ({1'b0, zm_c1} + (65'(1) << (ZK - 1))) >> ZK;
		zneg_v = 65'(0) - zr;
		if (zneg_c1) begin
			sat_z = zr > 65'h0_8000_0000;
			z_v   = sat_z ? STEPS_MIN : zneg_v[31:0];
		end else begin
			sat_z = zr > 65'h0_7FFF_FFFF;
			z_v   = sat_z ? STEPS_MAX : zr[31:0];
		end
		res_nx.left_chain_steps  = sat_l ? STEPS_MAX : q_l[31:0];
		res_nx.right_chain_steps = sat_r ? STEPS_MAX : q_r[31:0];
		res_nx.z_steps           = z_v;
		res_nx.overflow          = sat_l || sat_r || sat_z;
	end

	always_ff @(posedge clk) begin
		result <= res_nx;
	end

	// chain lengths are never negative
	a_chain_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!result.left_chain_steps[31] && !result.right_chain_steps[31]))
		else $error("negative chain step count");

	// overflow only comes with a saturated value
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.overflow) |->
			(result.left_chain_steps == STEPS_MAX || result.right_chain_steps == STEPS_MAX
			 || result.z_steps == STEPS_MAX || result.z_steps == STEPS_MIN))
		else $error("overflow without saturation");

	// a z steps per mm write lands in its register
	a_cfg_z: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_Z_STEPS_PER_MM)
			|=> (z_spm_q == $past(cfg_data)))
		else $error("z steps per mm write lost");

endmodule

### bench/tb_top.sv
// self-checking bench for the hanging plotter inverse kinematics pipeline
`timescale 1ns / 100ps

module tb_top;
	import hpik_pkg::*;

	localparam logic [3:0] REG_UNUSED = 4'd8;
	localparam int LATENCY_WAIT = 80;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [3:0]  idx;
		logic [31:0] data;
	} cfg_beat_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	target_t   target;
	logic      done;
	result_t   result;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [3:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor copy of the registers
	logic [22:0]        spacing_r;
	logic [22:0]        height_r;
	logic signed [23:0] y_offset_r;
	logic [17:0]        x_scale_r;
	logic [17:0]        y_scale_r;
	logic [31:0]        a_spm_r;
	logic [31:0]        b_spm_r;
	logic [31:0]        z_spm_r;

	target_t   pending_targets[$];
	cfg_beat_t pending_writes[$];
	result_t   expected_steps[$];

	int  sender_idle_pct;
	bit  target_taken;
	bit  cfg_taken;
	int  mismatches;
	int  cycles;

	hanging_plotter_inverse_kinematics dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.target(target),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] abs64(input longint signed v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// bitwise integer square root, floor
	function automatic logic [63:0] isqrt(input logic [127:0] s);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (128'(t) * 128'(t) <= s)
				r = t;
		end
		return r;
	endfunction

	// length times steps per mm, rounded half up, saturated
	function automatic logic [31:0] chain_steps(input logic [63:0] len, input logic [31:0] spm,
			inout logic ovf);
		logic [127:0] p;
		p = (128'(len) * 128'(spm) + (128'd1 << 41)) >> 42;
		if (p > 128'h7FFF_FFFF) begin
			ovf = 1'b1;
			return STEPS_MAX;
		end
		return p[31:0];
	endfunction

	function automatic result_t predict_steps(input target_t t);
		longint signed xc, yc, xs, ys;
		logic [63:0]  dy, dxl, dxr, zmag, zm, zr;
		logic [127:0] yy;
		logic         ovf;
		result_t      r;
		ovf = 1'b0;
		xc = longint'(spacing_r) << 15;
		yc = (longint'(height_r) << 15) + longint'(y_offset_r) * 65536;
		xs = longint'(t.pos_x) * longint'(x_scale_r);
		ys = longint'(t.pos_y) * longint'(y_scale_r);
		dy = abs64(yc - ys);
		dxl = abs64(xc + xs);
		dxr = abs64(xc - xs);
		yy = 128'(dy) * 128'(dy);
		r.left_chain_steps = chain_steps(isqrt(128'(dxl) * 128'(dxl) + yy), a_spm_r, ovf);
		r.right_chain_steps = chain_steps(isqrt(128'(dxr) * 128'(dxr) + yy), b_spm_r, ovf);
		// z: magnitude rounded half up, sign put back after saturation
		zmag = abs64(longint'(t.pos_z));
		zm = zmag * 64'(z_spm_r);
		zr = (zm + (64'd1 << 25)) >> 26;
		if (t.pos_z < 0) begin
			if (zr > 64'h8000_0000) begin
				ovf = 1'b1;
				zr = 64'h8000_0000;
			end
			r.z_steps = 32'(-zr);
		end else begin
			if (zr > 64'h7FFF_FFFF) begin
				ovf = 1'b1;
				zr = 64'h7FFF_FFFF;
			end
			r.z_steps = zr[31:0];
		end
		r.overflow = ovf;
		return r;
	endfunction

	task automatic apply_write(input logic [3:0] idx, input logic [31:0] d);
		case (idx)
			REG_MOTOR_SPACING: spacing_r = d[22:0];
			REG_FRAME_HEIGHT: height_r = d[22:0];
			REG_MOTOR_Y_OFFSET: y_offset_r = d[23:0];
			REG_X_SCALE: x_scale_r = d[17:0];
			REG_Y_SCALE: y_scale_r = d[17:0];
			REG_A_STEPS_PER_MM: a_spm_r = d;
			REG_B_STEPS_PER_MM: b_spm_r = d;
			REG_Z_STEPS_PER_MM: z_spm_r = d;
			default: ;
		endcase
	endtask

	// driver: one change per signal at each falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!cfg_valid || cfg_taken) begin
				if (pending_writes.size() > 0) begin
					cfg_beat_t w;
					w = pending_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= w.idx;
					cfg_data <= w.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
			if (!start || target_taken) begin
				if (pending_targets.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					start <= 1'b1;
					target <= pending_targets.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: takes beats, predicts and checks at the rising edge
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			target_taken = arst_n && start && !busy;
			cfg_taken = arst_n && cfg_valid && cfg_ready;
			if (target_taken)
				expected_steps.push_back(predict_steps(target));
			if (cfg_taken)
				apply_write(cfg_index, cfg_data);
			if (arst_n && done) begin
				if (expected_steps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %p", result);
				end else begin
					result_t e;
					e = expected_steps.pop_front();
					if (e.left_chain_steps !== result.left_chain_steps
							|| e.right_chain_steps !== result.right_chain_steps
							|| e.z_steps !== result.z_steps
							|| e.overflow !== result.overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", e, result);
					end
				end
			end
		end
	end

	task automatic push_write(input logic [3:0] idx, input logic [31:0] d);
		cfg_beat_t w;
		w.idx = idx;
		w.data = d;
		pending_writes.push_back(w);
	endtask

	task automatic load_config(input logic [31:0] sp, ht, off, xsc, ysc, aspm, bspm, zspm);
		push_write(REG_MOTOR_SPACING, sp);
		push_write(REG_FRAME_HEIGHT, ht);
		push_write(REG_MOTOR_Y_OFFSET, off);
		push_write(REG_X_SCALE, xsc);
		push_write(REG_Y_SCALE, ysc);
		push_write(REG_A_STEPS_PER_MM, aspm);
		push_write(REG_B_STEPS_PER_MM, bspm);
		push_write(REG_Z_STEPS_PER_MM, zspm);
		// unknown index is ignored
		push_write(REG_UNUSED | 4'($urandom_range(7)), $urandom);
		while (pending_writes.size() > 0 || cfg_valid)
			@(posedge clk);
	endtask

	task automatic push_target(input logic [31:0] x, y, z);
		target_t t;
		t.pos_x = x;
		t.pos_y = y;
		t.pos_z = z;
		pending_targets.push_back(t);
	endtask

	function automatic logic [31:0] rand_coord();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 3)
			return $urandom;
		else if (sel == 3)
			return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		else
			return 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
	endfunction

	task automatic drain();
		while (pending_targets.size() > 0 || start || expected_steps.size() > 0)
			@(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	initial begin
		cycles = 0;
		mismatches = 0;
		sender_idle_pct = 14;
		arst_n = 1'b0;
		start = 1'b0;
		target = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		target_taken = 0;
		cfg_taken = 0;
		spacing_r = '0;
		height_r = '0;
		y_offset_r = '0;
		x_scale_r = SCALE_ONE;
		y_scale_r = SCALE_ONE;
		a_spm_r = STEPS_ONE;
		b_spm_r = STEPS_ONE;
		z_spm_r = STEPS_ONE;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 8; ph++) begin
			sender_idle_pct = ph < 3 ? 14 : (ph < 6 ? 45 : 0);
			case (ph)
				0: ; // reset values
				1: load_config(32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, 32'h0003_FFFF,
						32'h0003_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: load_config(32'h0, 32'h0, 32'hFF80_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
				3: load_config(3000 * 1024, 1200 * 1024, -32'(80 * 1024), 32'd65536 + 120,
						32'd65536 - 300, 32'd50 << 16, 32'd50 << 16, 32'd400 << 16);
				default: load_config($urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
						$urandom >> $urandom_range(31));
			endcase
			if (ph == 0 || ph == 3) begin
				// field extremes and zero
				push_target(0, 0, 0);
				push_target(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				push_target(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
				push_target(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
				push_target(32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
				push_target(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				// z rounding at and next to half a step with the reset z steps per mm
				push_target(1024, -1024, 512);
				push_target(-1024, 1024, -512);
				push_target(0, 0, 511);
				push_target(0, 0, -513);
				// target near the point under a motor with the phase 3 config
				push_target(-32'(1500 * 1024), 32'(680 * 1024), 0);
				push_target(32'(1500 * 1024), 32'(680 * 1024), 0);
				push_target(32'h0055_5555, 32'hFFAA_AAAA, 32'h2AAA_AAAA);
				push_target(32'hFFAA_AAAA, 32'h0055_5555, 32'hD555_5555);
			end
			for (int i = 0; i < 95; i++)
				push_target(rand_coord(), rand_coord(), rand_coord());
			drain();
		end

		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

### filelist.f
sv/hpik_pkg.sv
sv/hpik_isqrt.sv
sv/hanging_plotter_inverse_kinematics.sv
bench/tb_top.sv
